// ----- rtl/core/wcpf_pkg.sv -----
// package: types, codes and constants of the waveform command parser and framer
`default_nettype none
package wcpf_pkg;

   localparam logic [31:0] KW_VOLT = 32'h564F4C54;
   localparam logic [31:0] KW_SIN  = 32'h0053494E;
   localparam logic [31:0] KW_RCT  = 32'h00524354;
   localparam logic [31:0] KW_OFF  = 32'h004F4646;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_VOLT = 3'd1;
   localparam logic [2:0] KIND_SIN  = 3'd2;
   localparam logic [2:0] KIND_RCT  = 3'd3;
   localparam logic [2:0] KIND_OFF  = 3'd4;

   localparam logic [1:0] PH_BLANK = 2'd0;
   localparam logic [1:0] PH_DIGIT = 2'd1;
   localparam logic [1:0] PH_DONE  = 2'd2;

   localparam logic [1:0] WAVE_DC   = 2'd0;
   localparam logic [1:0] WAVE_SINE = 2'd1;
   localparam logic [1:0] WAVE_RECT = 2'd2;

   localparam logic [1:0] TOK_KEYWORD = 2'd0;
   localparam logic [1:0] TOK_AMP     = 2'd1;
   localparam logic [1:0] TOK_FREQ    = 2'd2;
   localparam logic [1:0] TOK_EXTRA   = 2'd3;

   localparam logic [15:0] FRAME_MARK = 16'h8000;
   localparam logic [15:0] AMP_MASK   = 16'h1FFF;
   localparam logic [15:0] FREQ_MASK  = 16'h7FFF;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_flag;
   } step_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] frame_word;
      logic [1:0]  wave_kind;
      logic [15:0] amp_value;
      logic [15:0] freq_value;
   } rsp_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
             (c == 8'h0C) || (c == 8'h0D);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/wcpf_req_if.sv -----
// interface: character request channel
`default_nettype none
interface wcpf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last;

   modport source (output valid, output char_in, output last, input ready);
   modport sink (input valid, input char_in, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/wcpf_rsp_if.sv -----
// interface: parse result and spi frame channel
`default_nettype none
interface wcpf_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [31:0] frame_word;
   logic [1:0]  wave_kind;
   logic [15:0] amp_value;
   logic [15:0] freq_value;

   modport source (output valid, output ok, output frame_word, output wave_kind,
                   output amp_value, output freq_value, input ready);
   modport sink (input valid, input ok, input frame_word, input wave_kind,
                 input amp_value, input freq_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/wcpf_parser.sv -----
// module: per-character parse state, stored request and frame build
`default_nettype none
module wcpf_parser
   import wcpf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     fire,
   input  wire step_type step,
   output rsp_type       result
);

   logic [1:0]  tok_idx_ff, tok_idx_in;
   logic        in_tok_ff, in_tok_in;
   logic [31:0] kw_buf_ff, kw_buf_in;
   logic        kw_long_ff, kw_long_in;
   logic [2:0]  kw_kind_ff, kw_kind_in;
   logic [1:0]  num_phase_ff, num_phase_in;
   logic        num_neg_ff, num_neg_in;
   logic [15:0] num_acc_ff, num_acc_in;
   logic        str_end_ff, str_end_in;
   logic [1:0]  wave_ff, wave_in;
   logic [15:0] amp_ff, amp_in;
   logic [15:0] freq_ff, freq_in;

   always_comb begin
      logic [7:0]  c;
      logic        digit;
      logic [15:0] dval;
      logic [15:0] v;
      logic        do_finish;
      logic        ok;
      c          = step.char_code;
      digit      = (c >= CH_ZERO) && (c <= CH_NINE);
      dval       = {12'd0, c[3:0]};
      tok_idx_in   = tok_idx_ff;
      in_tok_in    = in_tok_ff;
      kw_buf_in    = kw_buf_ff;
      kw_long_in   = kw_long_ff;
      kw_kind_in   = kw_kind_ff;
      num_phase_in = num_phase_ff;
      num_neg_in   = num_neg_ff;
      num_acc_in   = num_acc_ff;
      str_end_in   = str_end_ff;
      wave_in      = wave_ff;
      amp_in       = amp_ff;
      freq_in      = freq_ff;
      do_finish    = step.last_flag;
      ok           = 1'b0;

      // character intake
      if (!str_end_ff) begin
         if (c == CH_NUL) begin
            str_end_in = 1'b1;
         end else if (c == CH_COLON) begin
            do_finish = 1'b1;
         end else begin
            if (!in_tok_ff) begin
               in_tok_in    = 1'b1;
               num_phase_in = PH_BLANK;
               num_neg_in   = 1'b0;
               num_acc_in   = 16'd0;
            end
            if (tok_idx_ff == TOK_KEYWORD) begin
               if (kw_buf_ff[31:24] != 8'd0) begin
                  kw_long_in = 1'b1;
               end else begin
                  kw_buf_in = {kw_buf_ff[23:0], c};
               end
            end else if (tok_idx_ff != TOK_EXTRA) begin
               unique case (num_phase_in)
                  PH_BLANK: begin
                     if (is_blank(c)) begin
                        num_phase_in = PH_BLANK;
                     end else if (c == CH_MINUS) begin
                        num_neg_in   = 1'b1;
                        num_phase_in = PH_DIGIT;
                     end else if (c == CH_PLUS) begin
                        num_phase_in = PH_DIGIT;
                     end else if (digit) begin
                        num_acc_in   = dval;
                        num_phase_in = PH_DIGIT;
                     end else begin
                        num_phase_in = PH_DONE;
                     end
                  end
                  PH_DIGIT: begin
                     if (digit) begin
                        num_acc_in = 16'((num_acc_in << 3) + (num_acc_in << 1) + dval);
                     end else begin
                        num_phase_in = PH_DONE;
                     end
                  end
                  default: begin
                     num_phase_in = num_phase_in;
                  end
               endcase
            end
         end
      end

      // token end
      v = num_neg_in ? 16'(16'd0 - num_acc_in) : num_acc_in;
      if (do_finish && in_tok_in) begin
         in_tok_in = 1'b0;
         unique case (tok_idx_in)
            TOK_KEYWORD: begin
               priority if (kw_long_in)          kw_kind_in = KIND_NONE;
               else if (kw_buf_in == KW_VOLT)    kw_kind_in = KIND_VOLT;
               else if (kw_buf_in == KW_SIN)     kw_kind_in = KIND_SIN;
               else if (kw_buf_in == KW_RCT)     kw_kind_in = KIND_RCT;
               else if (kw_buf_in == KW_OFF)     kw_kind_in = KIND_OFF;
               else                              kw_kind_in = KIND_NONE;
               unique case (kw_kind_in)
                  KIND_VOLT: wave_in = WAVE_DC;
                  KIND_SIN:  wave_in = WAVE_SINE;
                  KIND_RCT:  wave_in = WAVE_RECT;
                  KIND_OFF: begin
                     wave_in = WAVE_DC;
                     amp_in  = 16'd0;
                     freq_in = 16'd0;
                  end
                  default: wave_in = wave_in;
               endcase
            end
            TOK_AMP: begin
               if (kw_kind_in == KIND_VOLT || kw_kind_in == KIND_SIN ||
                   kw_kind_in == KIND_RCT) begin
                  amp_in = v;
               end
            end
            TOK_FREQ: begin
               if (kw_kind_in == KIND_SIN || kw_kind_in == KIND_RCT) begin
                  freq_in = v;
               end
            end
            default: begin
               tok_idx_in = tok_idx_in;
            end
         endcase
         if (tok_idx_in != TOK_EXTRA) begin
            tok_idx_in = 2'(tok_idx_in + 2'd1);
         end
      end

      unique case (kw_kind_in)
         KIND_VOLT: ok = (tok_idx_in >= TOK_FREQ);
         KIND_SIN:  ok = (tok_idx_in == TOK_EXTRA);
         KIND_RCT:  ok = (tok_idx_in == TOK_EXTRA);
         KIND_OFF:  ok = 1'b1;
         default:   ok = 1'b0;
      endcase

      result.ok         = ok;
      result.frame_word = {FRAME_MARK | {1'b0, wave_in, 13'd0} | (amp_in & AMP_MASK),
                           FRAME_MARK | (freq_in & FREQ_MASK)};
      result.wave_kind  = wave_in;
      result.amp_value  = amp_in;
      result.freq_value = freq_in;

      // command end returns the parse state to idle
      if (step.last_flag) begin
         tok_idx_in   = TOK_KEYWORD;
         in_tok_in    = 1'b0;
         kw_buf_in    = 32'd0;
         kw_long_in   = 1'b0;
         kw_kind_in   = KIND_NONE;
         num_phase_in = PH_BLANK;
         num_neg_in   = 1'b0;
         num_acc_in   = 16'd0;
         str_end_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_idx_ff   <= TOK_KEYWORD;
         in_tok_ff    <= 1'b0;
         kw_buf_ff    <= 32'd0;
         kw_long_ff   <= 1'b0;
         kw_kind_ff   <= KIND_NONE;
         num_phase_ff <= PH_BLANK;
         num_neg_ff   <= 1'b0;
         num_acc_ff   <= 16'd0;
         str_end_ff   <= 1'b0;
         wave_ff      <= WAVE_DC;
         amp_ff       <= 16'd0;
         freq_ff      <= 16'd0;
      end else if (fire) begin
         tok_idx_ff   <= tok_idx_in;
         in_tok_ff    <= in_tok_in;
         kw_buf_ff    <= kw_buf_in;
         kw_long_ff   <= kw_long_in;
         kw_kind_ff   <= kw_kind_in;
         num_phase_ff <= num_phase_in;
         num_neg_ff   <= num_neg_in;
         num_acc_ff   <= num_acc_in;
         str_end_ff   <= str_end_in;
         wave_ff      <= wave_in;
         amp_ff       <= amp_in;
         freq_ff      <= freq_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/wcpf_out_reg.sv -----
// module: result register driving the response channel
`default_nettype none
module wcpf_out_reg
   import wcpf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire rsp_type  data,
   output logic          free,
   wcpf_rsp_if.source    rsp_bus
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || rsp_bus.ready;
   assign valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.ok         = data_ff.ok;
   assign rsp_bus.frame_word = data_ff.frame_word;
   assign rsp_bus.wave_kind  = data_ff.wave_kind;
   assign rsp_bus.amp_value  = data_ff.amp_value;
   assign rsp_bus.freq_value = data_ff.freq_value;

endmodule
`default_nettype wire

// ----- rtl/core/waveform_command_parser_framer.sv -----
// top level: waveform command parser with spi frame output
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    char_in[7:0], last
//   rsp_bus   out   valid/ready    ok, frame_word[31:0], wave_kind[1:0], amp_value, freq_value
//
// one character per cycle while no final character stalls; a request is held in the input register,
// and a final character's result is loaded into the output register as it leaves
// the parse state is one step of logic per character
// reset is synchronous and returns parse state and stored request to zero
// a final character waits in the input register only while the output register is full
`default_nettype none
module waveform_command_parser_framer
   import wcpf_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   wcpf_req_if.sink   req_bus,
   wcpf_rsp_if.source rsp_bus
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       out_free;
   logic       stage_fire;
   logic       req_take;
   step_type   step;
   rsp_type    result;

   assign stage_fire    = in_valid_ff && (!in_last_ff || out_free);
   assign req_bus.ready = !in_valid_ff || stage_fire;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign in_valid_in   = req_take ? 1'b1 : (stage_fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_bus.char_in;
         in_last_ff <= req_bus.last;
      end
   end

   assign step.char_code = in_char_ff;
   assign step.last_flag = in_last_ff;

   wcpf_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (stage_fire),
      .step   (step),
      .result (result)
   );

   wcpf_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (stage_fire && in_last_ff),
      .data    (result),
      .free    (out_free),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTH
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !stage_fire |=> in_valid_ff)
      else $error("input register dropped a stalled request");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(stage_fire && in_last_ff))
      else $error("response without a final character");

   a_wave_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.wave_kind != 2'd3)
      else $error("illegal waveform code");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_take && in_valid_ff |-> stage_fire)
      else $error("request taken into a full input register");
`endif

endmodule
`default_nettype wire

// ----- sim/wcpf_frame_checker.sv -----
`timescale 1ns / 100ps
// checker: predicts parse results and spi frames and compares them with the result channel
module wcpf_frame_checker
   import wcpf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   wcpf_req_if       req_mon,
   wcpf_rsp_if       rsp_mon,
   output int        fail_count,
   output int        due_count,
   output int        frames_checked,
   output int        frames_ok
);

   logic [1:0]  tok_count;
   logic        in_tok;
   logic [31:0] kw_buf;
   logic        kw_overflow;
   logic [2:0]  kw_kind;
   logic [1:0]  num_phase;
   logic        num_neg;
   logic [15:0] num_acc;
   logic        str_done;
   logic [1:0]  req_wave;
   logic [15:0] req_amp;
   logic [15:0] req_freq;

   rsp_type frames_due[$];

   function automatic logic blank_char(input logic [7:0] c);
      return c == " " || c == "\t" || c == "\n" || c == "\v" || c == "\f" || c == "\r";
   endfunction

   task clear_parse();
      tok_count   = TOK_KEYWORD;
      in_tok      = 1'b0;
      kw_buf      = '0;
      kw_overflow = 1'b0;
      kw_kind     = KIND_NONE;
      num_phase   = PH_BLANK;
      num_neg     = 1'b0;
      num_acc     = '0;
      str_done    = 1'b0;
   endtask

   task close_token();
      logic [15:0] value;
      if (in_tok) begin
         in_tok = 1'b0;
         value = num_neg ? 16'd0 - num_acc : num_acc;
         case (tok_count)
            TOK_KEYWORD: begin
               if (kw_overflow) begin
                  kw_kind = KIND_NONE;
               end else begin
                  case (kw_buf)
                     KW_VOLT: kw_kind = KIND_VOLT;
                     KW_SIN:  kw_kind = KIND_SIN;
                     KW_RCT:  kw_kind = KIND_RCT;
                     KW_OFF:  kw_kind = KIND_OFF;
                     default: kw_kind = KIND_NONE;
                  endcase
               end
               case (kw_kind)
                  KIND_VOLT: req_wave = WAVE_DC;
                  KIND_SIN:  req_wave = WAVE_SINE;
                  KIND_RCT:  req_wave = WAVE_RECT;
                  KIND_OFF: begin
                     req_wave = WAVE_DC;
                     req_amp  = '0;
                     req_freq = '0;
                  end
                  default: ;
               endcase
            end
            TOK_AMP: begin
               if (kw_kind == KIND_VOLT || kw_kind == KIND_SIN || kw_kind == KIND_RCT)
                  req_amp = value;
            end
            TOK_FREQ: begin
               if (kw_kind == KIND_SIN || kw_kind == KIND_RCT)
                  req_freq = value;
            end
            default: ;
         endcase
         if (tok_count != TOK_EXTRA)
            tok_count = tok_count + 2'd1;
      end
   endtask

   task feed_char(input logic [7:0] c);
      logic is_digit;
      is_digit = c >= CH_ZERO && c <= CH_NINE;
      if (c == CH_NUL) begin
         str_done = 1'b1;
      end else if (c == CH_COLON) begin
         close_token();
      end else begin
         if (!in_tok) begin
            in_tok    = 1'b1;
            num_phase = PH_BLANK;
            num_neg   = 1'b0;
            num_acc   = '0;
         end
         if (tok_count == TOK_KEYWORD) begin
            if (kw_buf[31:24] != 8'h00)
               kw_overflow = 1'b1;
            else
               kw_buf = {kw_buf[23:0], c};
         end else if (tok_count != TOK_EXTRA) begin
            case (num_phase)
               PH_BLANK: begin
                  if (blank_char(c)) begin
                     num_phase = PH_BLANK;
                  end else if (c == CH_MINUS) begin
                     num_neg   = 1'b1;
                     num_phase = PH_DIGIT;
                  end else if (c == CH_PLUS) begin
                     num_phase = PH_DIGIT;
                  end else if (is_digit) begin
                     num_acc   = {8'h00, c - CH_ZERO};
                     num_phase = PH_DIGIT;
                  end else begin
                     num_phase = PH_DONE;
                  end
               end
               PH_DIGIT: begin
                  if (is_digit)
                     num_acc = num_acc * 16'd10 + {8'h00, c - CH_ZERO};
                  else
                     num_phase = PH_DONE;
               end
               default: ;
            endcase
         end
      end
   endtask

   task parse_step(input logic [7:0] c, input logic fin);
      rsp_type     frame;
      logic [15:0] hi_word;
      logic [15:0] lo_word;
      if (!str_done)
         feed_char(c);
      if (fin) begin
         close_token();
         case (kw_kind)
            KIND_VOLT:          frame.ok = tok_count >= TOK_FREQ;
            KIND_SIN, KIND_RCT: frame.ok = tok_count >= TOK_EXTRA;
            KIND_OFF:           frame.ok = 1'b1;
            default:            frame.ok = 1'b0;
         endcase
         hi_word = FRAME_MARK | {1'b0, req_wave, 13'd0} | (req_amp & AMP_MASK);
         lo_word = FRAME_MARK | (req_freq & FREQ_MASK);
         frame.frame_word = {hi_word, lo_word};
         frame.wave_kind  = req_wave;
         frame.amp_value  = req_amp;
         frame.freq_value = req_freq;
         frames_due.push_back(frame);
         due_count++;
         clear_parse();
      end
   endtask

   task report_field(input string field, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: frame %0d %s expected %h, actual %h",
                  $time, frames_checked, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_parse();
         req_wave = WAVE_DC;
         req_amp  = '0;
         req_freq = '0;
         frames_due.delete();
         due_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (frames_due.size() == 0) begin
               $display("%0t: frame with none expected, actual ok %b word %h",
                        $time, rsp_mon.ok, rsp_mon.frame_word);
               fail_count++;
            end else begin
               want = frames_due.pop_front();
               due_count--;
               report_field("ok", want.ok, rsp_mon.ok);
               report_field("frame_word", want.frame_word, rsp_mon.frame_word);
               report_field("wave_kind", want.wave_kind, rsp_mon.wave_kind);
               report_field("amp_value", want.amp_value, rsp_mon.amp_value);
               report_field("freq_value", want.freq_value, rsp_mon.freq_value);
               if (rsp_mon.ok)
                  frames_ok++;
               frames_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            parse_step(req_mon.char_in, req_mon.last);
      end
   end

endmodule

// ----- sim/waveform_command_parser_framer_tb.sv -----
`timescale 1ns / 100ps
// testbench top: command stimulus, handshake pressure and verdict for the waveform parser
module waveform_command_parser_framer_tb;
   import wcpf_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int RANDOM_CHARS = 880;

   logic clock;
   logic reset;

   int sender_idle_pct = 0;
   int sink_stall_pct  = 0;
   int idle_cycles     = 0;
   int chars_sent      = 0;
   int commands_sent   = 0;
   int fail_count;
   int due_count;
   int frames_checked;
   int frames_ok;

   logic [7:0] cmd_text[$];
   string keywords[4] = '{"VOLT", "SIN", "RCT", "OFF"};
   string blanks = " \t\n\v\f\r";

   wcpf_req_if req_bus();
   wcpf_rsp_if rsp_bus();

   waveform_command_parser_framer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   wcpf_frame_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .fail_count     (fail_count),
      .due_count      (due_count),
      .frames_checked (frames_checked),
      .frames_ok      (frames_ok)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
   end

   // watchdog on cycles where no request and no result moves
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog, nothing moved for %0d cycles", $time, IDLE_LIMIT);
         $display("waveform_command_parser_framer_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_char(input logic [7:0] c, input logic fin);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.char_in <= c;
      req_bus.last    <= fin;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_command();
      foreach (cmd_text[i])
         send_char(cmd_text[i], i == cmd_text.size() - 1);
      cmd_text.delete();
      commands_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (due_count != 0)
         @(negedge clock);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         cmd_text.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      add_text(s);
      send_command();
   endtask

   task automatic add_colons();
      int n;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
      repeat (n) cmd_text.push_back(CH_COLON);
   endtask

   task automatic add_number();
      int digits;
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 2)) cmd_text.push_back(blanks[$urandom_range(0, 5)]);
      case ($urandom_range(0, 9))
         0, 1:    cmd_text.push_back(CH_MINUS);
         2:       cmd_text.push_back(CH_PLUS);
         default: ;
      endcase
      digits = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
      repeat (digits) cmd_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0)
         cmd_text.push_back("a" + 8'($urandom_range(0, 25)));
   endtask

   task automatic build_good();
      int kind;
      kind = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0)
         add_colons();
      add_text(keywords[kind]);
      if (kind != 3) begin
         add_colons();
         add_number();
         if (kind != 0) begin
            add_colons();
            add_number();
         end
      end
      if ($urandom_range(0, 9) == 0)
         add_colons();
   endtask

   task automatic build_broken();
      int n;
      case ($urandom_range(0, 5))
         0: repeat ($urandom_range(1, 8)) cmd_text.push_back(8'($urandom_range(0, 255)));
         1: begin
            build_good();
            cmd_text[$urandom_range(0, cmd_text.size() - 1)] = 8'($urandom_range(0, 255));
         end
         2: begin
            build_good();
            n = $urandom_range(1, cmd_text.size() - 1);
            repeat (n) void'(cmd_text.pop_back());
         end
         3: begin
            build_good();
            cmd_text.insert($urandom_range(0, cmd_text.size() - 1), CH_NUL);
         end
         4: begin
            build_good();
            add_colons();
            add_number();
            if ($urandom_range(0, 1) == 1) begin
               add_colons();
               add_number();
            end
         end
         default: begin
            add_text(keywords[$urandom_range(0, 3)]);
            cmd_text.push_back("A" + 8'($urandom_range(0, 25)));
            add_colons();
            add_number();
         end
      endcase
   endtask

   initial begin
      int random_base;
      int phase_now;
      int next_phase;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.char_in = 8'h00;
      req_bus.last    = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      send_text("VOLT:100");
      send_text("SIN:4000:1000");
      send_text("RCT:8191:32767");
      send_text("SIN:65535:65535");
      send_text("RCT:-1:70000");
      send_text("VOLT:99");
      send_text("OFF");
      send_text("OFF:5:5");
      send_text("::RCT:::7::9:");
      send_text(":");
      cmd_text.push_back(CH_NUL);
      send_command();
      send_text("SIN:25");
      send_text("VOLTS:5");
      send_text("volt:5");
      send_text("SIN:1:2:3:4");
      send_text("VOLT: \t+12ab");
      send_text("RCT:\v\f\r\n-0x5:- 3");
      // zero byte cuts the string short
      add_text("VOLT:12");
      cmd_text.push_back(CH_NUL);
      add_text("Z:9");
      send_command();
      add_text("RCT:");
      cmd_text.push_back(8'hFF);
      add_text("9:");
      cmd_text.push_back(8'h80);
      send_command();

      random_base = chars_sent;
      phase_now   = -1;
      while (chars_sent - random_base < RANDOM_CHARS) begin
         next_phase = (chars_sent - random_base) * 4 / RANDOM_CHARS;
         if (next_phase != phase_now) begin
            wait_drained();
            phase_now = next_phase;
            case (phase_now)
               0: begin
                  sender_idle_pct = 0;
                  sink_stall_pct  = 0;
               end
               1: begin
                  sender_idle_pct = 47;
                  sink_stall_pct  = 0;
               end
               2: begin
                  sender_idle_pct = 0;
                  sink_stall_pct  = 47;
               end
               default: begin
                  sender_idle_pct = 32;
                  sink_stall_pct  = 32;
               end
            endcase
         end
         if ($urandom_range(0, 3) == 0)
            build_broken();
         else
            build_good();
         send_command();
      end

      wait_drained();
      repeat (8) @(negedge clock);
      $display("covered %0d characters in %0d commands across four idle and stall mixes",
               chars_sent, commands_sent);
      $display("compared %0d frames, %0d of them parsed ok, %0d mismatches",
               frames_checked, frames_ok, fail_count);
      if (fail_count == 0)
         $display("waveform_command_parser_framer_tb: done, clean");
      else
         $display("waveform_command_parser_framer_tb: done, errors");
      $finish;
   end

endmodule
